// ===== rtl/core/sdne_pkg.sv =====
// Shared types, constants, sigmoid table and microprogram for the sigmoid dual-number unit.
package sdne_pkg;

  // Word format: signed fixed point, 32 bits
  localparam int WORD_W         = 32;
  localparam int FRAC_BITS      = 24;
  localparam int TABLE_SEGMENTS = 256;
  localparam int SEG_BITS       = $clog2(TABLE_SEGMENTS);
  localparam int SIG_W          = FRAC_BITS + 1;            // s in [0, 1.0]
  localparam int ZM_W           = FRAC_BITS + 3;            // |z| < 8
  localparam int FRB            = ZM_W - SEG_BITS;          // interpolation fraction bits
  localparam int IDX_W          = SEG_BITS + 1;             // table has one extra point
  localparam int PROD_W         = 2 * WORD_W;

  localparam logic [SIG_W-1:0]  ONE_Q     = SIG_W'(1) << FRAC_BITS;
  localparam logic [WORD_W-1:0] STEEP_RST = WORD_W'(1) << FRAC_BITS;

  typedef logic [SIG_W-1:0] sig_tab_t [TABLE_SEGMENTS+1];

  // Unsigned 64-bit quotient by restoring shift and subtract
  function automatic logic [63:0] udiv64(logic [63:0] num, logic [63:0] den);
    logic [63:0] quo;
    logic [64:0] rem;
    quo = '0;
    rem = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], num[i]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Sigmoid points s(8*j/N) built in integers: Taylor exp(-u), squared three times
  function automatic sig_tab_t build_sig_tab();
    sig_tab_t    t;
    logic [63:0] u;
    logic [63:0] term;
    logic [63:0] pos;
    logic [63:0] neg;
    logic [63:0] e;
    logic [63:0] d;
    for (int j = 0; j <= TABLE_SEGMENTS; j++) begin
      u    = (64'(j) << 31) / TABLE_SEGMENTS;
      term = 64'd1 << 31;
      pos  = 64'd1 << 31;
      neg  = 64'd0;
      for (int n = 1; n <= 16; n++) begin
        term = udiv64((term * u) >> 31, 64'(n));
        if (n % 2 == 1) begin
          neg = neg + term;
        end else begin
          pos = pos + term;
        end
      end
      e = (pos >= neg) ? pos - neg : 64'd0;
      for (int sq = 0; sq < 3; sq++) begin
        e = (e * e) >> 31;
      end
      d    = (64'd1 << 31) + e;
      t[j] = SIG_W'(udiv64((64'd1 << (31 + FRAC_BITS)) + (d >> 1), d));
    end
    return t;
  endfunction

  localparam sig_tab_t SIG_TAB = build_sig_tab();

  // Microprogram addresses
  typedef enum logic [3:0] {
    UC_IDLE,
    UC_V_MULZ,
    UC_V_TAB,
    UC_V_MULI,
    UC_V_SIG,
    UC_V_MULQ,
    UC_V_MULF,
    UC_V_FIN,
    UC_G_MUL,
    UC_G_FIN,
    UC_G_NONE
  } upc_e;

  typedef enum logic [1:0] {MA_KMAG, MA_WMAG, MA_DIFF, MA_SIG} mul_a_e;
  typedef enum logic [2:0] {MB_WMAG, MB_FMAG, MB_FRAC, MB_ONE_M_S, MB_PROD_HI} mul_b_e;
  typedef enum logic [1:0] {RES_SIG, RES_GRAD, RES_ZERO} res_e;
  typedef enum logic [1:0] {COND_NEVER, COND_ALWAYS, COND_ZSAT} cond_e;

  // One control word per microprogram step
  typedef struct packed {
    mul_a_e mul_a;
    mul_b_e mul_b;
    logic   mul_en;
    logic   ld_tab;      // capture table points and z flags
    logic   ld_sig;      // form s from the interpolation product
    logic   upd_factor;  // store k*s*(1-s), open or close the term
    logic   clr_on_last; // gradient with last closes the term
    logic   out_load;    // hand a result to the output register
    res_e   res_sel;
    cond_e  cond;
    upc_e   target;
    logic   done;
  } uword_t;

  // Control word plus step-advance qualifier
  typedef struct packed {
    uword_t uw;
    logic   adv;
  } sdne_ctrl_t;

  localparam uword_t UW_NOP = '{
    mul_a: MA_KMAG, mul_b: MB_WMAG, mul_en: 1'b0, ld_tab: 1'b0, ld_sig: 1'b0,
    upd_factor: 1'b0, clr_on_last: 1'b0, out_load: 1'b0, res_sel: RES_ZERO,
    cond: COND_NEVER, target: UC_IDLE, done: 1'b0};

  // Control store
  function automatic uword_t uc_rom(upc_e a);
    uword_t w;
    w = UW_NOP;
    case (a)
      UC_IDLE: ;
      UC_V_MULZ: begin
        w.mul_a  = MA_KMAG;
        w.mul_b  = MB_WMAG;
        w.mul_en = 1'b1;
      end
      UC_V_TAB: begin
        w.ld_tab = 1'b1;
        w.cond   = COND_ZSAT;
        w.target = UC_V_SIG;
      end
      UC_V_MULI: begin
        w.mul_a  = MA_DIFF;
        w.mul_b  = MB_FRAC;
        w.mul_en = 1'b1;
      end
      UC_V_SIG: begin
        w.ld_sig = 1'b1;
      end
      UC_V_MULQ: begin
        w.mul_a  = MA_SIG;
        w.mul_b  = MB_ONE_M_S;
        w.mul_en = 1'b1;
      end
      UC_V_MULF: begin
        w.mul_a  = MA_KMAG;
        w.mul_b  = MB_PROD_HI;
        w.mul_en = 1'b1;
      end
      UC_V_FIN: begin
        w.upd_factor = 1'b1;
        w.out_load   = 1'b1;
        w.res_sel    = RES_SIG;
        w.done       = 1'b1;
      end
      UC_G_MUL: begin
        w.mul_a  = MA_WMAG;
        w.mul_b  = MB_FMAG;
        w.mul_en = 1'b1;
      end
      UC_G_FIN: begin
        w.clr_on_last = 1'b1;
        w.out_load    = 1'b1;
        w.res_sel     = RES_GRAD;
        w.done        = 1'b1;
      end
      UC_G_NONE: begin
        w.out_load = 1'b1;
        w.res_sel  = RES_ZERO;
        w.done     = 1'b1;
      end
      default: w = UW_NOP;
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/core/sdne_useq.sv =====
// Microcode sequencer: step counter, control store and jump logic.
module sdne_useq import sdne_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_fire_i,       // input transaction this cycle
  input  logic       is_value_i,
  input  logic       factor_valid_i,
  input  logic       zsat_i,
  input  logic       out_busy_i,      // output register full and not drained
  output sdne_ctrl_t ctrl_o,
  output logic       idle_o
);

  upc_e   upc_q, upc_d;
  uword_t uw;
  logic   adv;
  logic   jump;

  assign uw     = uc_rom(upc_q);
  // only a step that hands off a result can stall
  assign adv    = !(uw.out_load && out_busy_i);
  assign idle_o = (upc_q == UC_IDLE);
  assign ctrl_o = '{uw: uw, adv: adv};

  always_comb begin
    case (uw.cond)
      COND_ALWAYS: jump = 1'b1;
      COND_ZSAT:   jump = zsat_i;
      default:     jump = 1'b0;
    endcase
  end

  // next step: dispatch from idle, jump, return, or fall through
  always_comb begin
    upc_d = upc_q;
    if (upc_q == UC_IDLE) begin
      if (in_fire_i) begin
        if (is_value_i) begin
          upc_d = UC_V_MULZ;
        end else if (factor_valid_i) begin
          upc_d = UC_G_MUL;
        end else begin
          upc_d = UC_G_NONE;
        end
      end
    end else if (adv) begin
      if (jump) begin
        upc_d = uw.target;
      end else if (uw.done) begin
        upc_d = UC_IDLE;
      end else begin
        upc_d = upc_e'(upc_q + 4'd1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= UC_IDLE;
    end else begin
      upc_q <= upc_d;
    end
  end

endmodule

// ===== rtl/core/sdne_dpath.sv =====
// Datapath: shared multiplier, sigmoid table interpolation, gradient factor state.
module sdne_dpath import sdne_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sdne_ctrl_t        ctrl_i,
  input  logic              cfg_we_i,
  input  logic [WORD_W-1:0] cfg_wdata_i,
  input  logic [WORD_W-1:0] item_word_i,
  input  logic              item_last_i,
  output logic              zsat_o,
  output logic              factor_valid_o,
  output logic [WORD_W-1:0] res_word_o,
  output logic              res_sat_o
);

  logic [WORD_W-1:0] steep_q;
  logic [WORD_W-1:0] factor_q, factor_d;
  logic              fvalid_q, fvalid_d;
  logic [PROD_W-1:0] prod_q;
  logic [SIG_W-1:0]  lo_q, dmag_q, s_q, s_d;
  logic              dneg_q, zsat_q, negz_q;
  logic [FRB-1:0]    frac_q;

  logic [WORD_W-1:0] kmag, wmag, fmag, mul_a, mul_b;
  logic [IDX_W-1:0]  idx_lo, idx_hi;
  logic [SIG_W-1:0]  tab_lo, tab_hi;
  logic [SIG_W:0]    sp;
  logic [SIG_W-1:0]  sp_c, delta;
  logic [WORD_W-1:0] fm;
  logic [PROD_W-FRAC_BITS-1:0] gm;
  logic              gneg, gover;
  logic [WORD_W-1:0] glim, gval;

  // magnitudes of signed words
  assign kmag = steep_q[WORD_W-1] ? -steep_q : steep_q;
  assign wmag = item_word_i[WORD_W-1] ? -item_word_i : item_word_i;
  assign fmag = factor_q[WORD_W-1] ? -factor_q : factor_q;

  // shared multiplier operand select
  always_comb begin
    case (ctrl_i.uw.mul_a)
      MA_KMAG: mul_a = kmag;
      MA_WMAG: mul_a = wmag;
      MA_DIFF: mul_a = WORD_W'(dmag_q);
      MA_SIG:  mul_a = WORD_W'(s_q);
      default: mul_a = '0;
    endcase
  end

  always_comb begin
    case (ctrl_i.uw.mul_b)
      MB_WMAG:    mul_b = wmag;
      MB_FMAG:    mul_b = fmag;
      MB_FRAC:    mul_b = WORD_W'(frac_q);
      MB_ONE_M_S: mul_b = WORD_W'(ONE_Q - s_q);
      MB_PROD_HI: mul_b = prod_q[FRAC_BITS +: WORD_W];
      default:    mul_b = '0;
    endcase
  end

  // |z| = |k|*|x| >> FRAC; saturated when |z| >= 8
  assign zsat_o = |prod_q[PROD_W-1:FRAC_BITS+ZM_W];
  assign idx_lo = {1'b0, prod_q[FRAC_BITS+FRB +: SEG_BITS]};
  assign idx_hi = idx_lo + IDX_W'(1);
  assign tab_lo = SIG_TAB[idx_lo];
  assign tab_hi = SIG_TAB[idx_hi];

  // interpolated point, clamped, then mirrored for negative z
  assign delta = prod_q[FRB +: SIG_W];
  always_comb begin
    if (dneg_q) begin
      sp = {1'b0, lo_q} - {1'b0, delta};
    end else begin
      sp = {1'b0, lo_q} + {1'b0, delta};
    end
    if (zsat_q || sp > {1'b0, ONE_Q}) begin
      sp_c = ONE_Q;
    end else begin
      sp_c = sp[SIG_W-1:0];
    end
    s_d = negz_q ? ONE_Q - sp_c : sp_c;
  end

  // gradient factor k*s*(1-s)
  assign fm = prod_q[FRAC_BITS +: WORD_W];
  always_comb begin
    factor_d = factor_q;
    fvalid_d = fvalid_q;
    if (ctrl_i.uw.upd_factor) begin
      factor_d = steep_q[WORD_W-1] ? -fm : fm;
      fvalid_d = !item_last_i;
    end else if (ctrl_i.uw.clr_on_last && item_last_i) begin
      fvalid_d = 1'b0;
    end
  end

  // gradient product with clipping
  assign gm    = prod_q[PROD_W-1:FRAC_BITS];
  assign gneg  = item_word_i[WORD_W-1] ^ factor_q[WORD_W-1];
  assign glim  = gneg ? {1'b1, {(WORD_W-1){1'b0}}} : {1'b0, {(WORD_W-1){1'b1}}};
  assign gover = (|gm[PROD_W-FRAC_BITS-1:WORD_W]) || (gm[WORD_W-1:0] > glim);
  assign gval  = gover ? glim : gm[WORD_W-1:0];

  always_comb begin
    case (ctrl_i.uw.res_sel)
      RES_SIG: begin
        res_word_o = WORD_W'(s_q);
        res_sat_o  = 1'b0;
      end
      RES_GRAD: begin
        res_word_o = gneg ? -gval : gval;
        res_sat_o  = gover;
      end
      default: begin
        res_word_o = '0;
        res_sat_o  = 1'b0;
      end
    endcase
  end

  assign factor_valid_o = fvalid_q;

  // control state: steepness, factor, term open flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      steep_q  <= STEEP_RST;
      factor_q <= '0;
      fvalid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        steep_q <= cfg_wdata_i;
      end
      if (ctrl_i.adv) begin
        factor_q <= factor_d;
        fvalid_q <= fvalid_d;
      end
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    if (ctrl_i.adv && ctrl_i.uw.mul_en) begin
      prod_q <= mul_a * mul_b;
    end
    if (ctrl_i.adv && ctrl_i.uw.ld_tab) begin
      lo_q   <= tab_lo;
      dneg_q <= tab_hi < tab_lo;
      dmag_q <= (tab_hi < tab_lo) ? tab_lo - tab_hi : tab_hi - tab_lo;
      frac_q <= prod_q[FRAC_BITS +: FRB];
      zsat_q <= zsat_o;
      negz_q <= (steep_q[WORD_W-1] ^ item_word_i[WORD_W-1]) &&
                (|prod_q[PROD_W-1:FRAC_BITS]);
    end
    if (ctrl_i.adv && ctrl_i.uw.ld_sig) begin
      s_q <= s_d;
    end
  end

endmodule

// ===== rtl/core/sigmoid_dual_number_eval_unit.sv =====
// Top level: stream ports, item and output registers, sequencer and datapath.
//
//   channel   direction  transaction          payload
//   s_axis    in         tvalid & tready      tdata=word, tuser=is_value, tlast=last_in
//   m_axis    out        tvalid & tready      tdata=result_word, tuser={saturated,value_out},
//                                             tlast=last_out
//   cfg       in         cfg_we_i             cfg_wdata_i = steepness
//
// One item at a time; the microprogram on the single shared 32x32 multiplier sets the time.
// Value item: k*x, table fetch, interpolation product (skipped when |k*x| >= 8), s, s*(1-s),
// times k, result. Gradient item: multiply and result with an open term, zero without one.
// Reset clears the sequencer, the output register, the term flag and sets steepness to 1.0.
// A full output register stalls only the final step, and the input waits with it; once a
// result sits in the output register the next item is taken while it drains.
module sigmoid_dual_number_eval_unit import sdne_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [WORD_W-1:0] s_axis_tdata,   // [31:0] word
  input  logic              s_axis_tuser,   // [0] is_value
  input  logic              s_axis_tlast,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [WORD_W-1:0] m_axis_tdata,   // [31:0] result_word
  output logic [1:0]        m_axis_tuser,   // [0] value_out, [1] saturated
  output logic              m_axis_tlast,
  input  logic              cfg_we_i,
  input  logic [WORD_W-1:0] cfg_wdata_i
);

  sdne_ctrl_t        ctrl;
  logic              idle, in_fire, out_busy;
  logic              zsat, fvalid;
  logic [WORD_W-1:0] res_word;
  logic              res_sat;
  logic [WORD_W-1:0] item_word_q;
  logic              item_last_q;
  logic              out_valid_q, out_valid_d;
  logic [WORD_W-1:0] out_word_q;
  logic              out_value_q, out_sat_q, out_last_q;
  logic              out_ld;

  assign s_axis_tready = idle;
  assign in_fire       = s_axis_tvalid && idle;
  assign out_busy      = out_valid_q && !m_axis_tready;
  assign out_ld        = ctrl.uw.out_load && ctrl.adv;

  sdne_useq u_useq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_fire_i      (in_fire),
    .is_value_i     (s_axis_tuser),
    .factor_valid_i (fvalid),
    .zsat_i         (zsat),
    .out_busy_i     (out_busy),
    .ctrl_o         (ctrl),
    .idle_o         (idle)
  );

  sdne_dpath u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctrl_i         (ctrl),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .item_word_i    (item_word_q),
    .item_last_i    (item_last_q),
    .zsat_o         (zsat),
    .factor_valid_o (fvalid),
    .res_word_o     (res_word),
    .res_sat_o      (res_sat)
  );

  // input item capture
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      item_word_q <= s_axis_tdata;
      item_last_q <= s_axis_tlast;
    end
  end

  // output register valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    if (out_ld) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (out_ld) begin
      out_word_q  <= res_word;
      out_value_q <= (ctrl.uw.res_sel == RES_SIG);
      out_sat_q   <= res_sat;
      out_last_q  <= item_last_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_word_q;
  assign m_axis_tuser  = {out_sat_q, out_value_q};
  assign m_axis_tlast  = out_last_q;

endmodule

// ===== dv/tb_top.sv =====
// Self-checking stream testbench for the sigmoid dual-number evaluation unit.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          W          = sdne_pkg::WORD_W;
  localparam int          FB         = 24;
  localparam int          SEGS       = 256;
  localparam logic [63:0] Q_ONE      = 64'd1 << FB;
  localparam logic [63:0] Z_LIMIT    = 64'd8 << FB;
  localparam logic [W-1:0] STEEP_ONE = 32'h0100_0000;
  localparam int          CYCLE_LIMIT = 400000;
  localparam int          DRAIN_TAIL  = 20;

  // One output transaction as the checker sees it
  typedef struct packed {
    logic [W-1:0] word;
    logic         value;
    logic         last;
    logic         sat;
  } dual_result_t;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [W-1:0] s_axis_tdata;
  logic         s_axis_tuser;
  logic         s_axis_tlast;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [W-1:0] m_axis_tdata;
  logic [1:0]   m_axis_tuser;
  logic         m_axis_tlast;
  logic         cfg_we_i;
  logic [W-1:0] cfg_wdata_i;

  sigmoid_dual_number_eval_unit u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  // Predictor state: table, slope, held factor and term flag
  logic [63:0]  sig_points [SEGS+1];
  logic [W-1:0] pred_steep;
  logic [W-1:0] pred_factor;
  logic         pred_term_open;

  dual_result_t pending_results [$];
  int           fail_count;
  int           items_sent;
  int           cycle_count;
  bit           sender_quiet;
  bit           receiver_quiet;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Sigmoid points s(8j/N): Taylor series of exp(-u), squared three times
  function automatic void build_sig_points();
    logic [63:0] u, term, pos, neg, e, d;
    for (int j = 0; j <= SEGS; j++) begin
      u    = (64'(j) << 31) / SEGS;
      term = 64'd1 << 31;
      pos  = 64'd1 << 31;
      neg  = 64'd0;
      for (int n = 1; n <= 16; n++) begin
        term = ((term * u) >> 31) / 64'(n);
        if (n & 1) neg += term;
        else pos += term;
      end
      e = (pos >= neg) ? pos - neg : 64'd0;
      repeat (3) e = (e * e) >> 31;
      d = (64'd1 << 31) + e;
      sig_points[j] = ((64'd1 << (31 + FB)) + d / 2) / d;
    end
  endfunction

  function automatic logic [63:0] abs_word(logic [W-1:0] v);
    return v[W-1] ? {32'd0, ~v + 32'd1} : {32'd0, v};
  endfunction

  // s(k*x) in [0, 1.0], interpolated, with the negative side mirrored
  function automatic logic [63:0] sigmoid_at(logic [W-1:0] k, logic [W-1:0] x);
    logic [63:0] zm, p, seg, frac, lo, hi, sp;
    logic        negz;
    zm   = (abs_word(k) * abs_word(x)) >> FB;
    negz = (k[W-1] != x[W-1]) && zm != 0;
    if (zm >= Z_LIMIT) begin
      sp = Q_ONE;
    end else begin
      p    = zm * SEGS;
      seg  = p >> (FB + 3);
      frac = p & ((64'd1 << (FB + 3)) - 1);
      if (seg >= SEGS) seg = SEGS - 1;
      lo = sig_points[seg];
      hi = sig_points[seg + 1];
      if (hi >= lo) sp = lo + (((hi - lo) * frac) >> (FB + 3));
      else sp = lo - (((lo - hi) * frac) >> (FB + 3));
      if (sp > Q_ONE) sp = Q_ONE;
    end
    return negz ? Q_ONE - sp : sp;
  endfunction

  // Expected result of one item; advances the predicted term state
  function automatic dual_result_t predict_dual_result(logic is_val, logic [W-1:0] w,
                                                       logic last);
    dual_result_t r;
    logic [63:0]  s, q, fm, m, lim;
    logic         neg;
    r.word  = '0;
    r.value = is_val;
    r.last  = last;
    r.sat   = 1'b0;
    if (is_val) begin
      s  = sigmoid_at(pred_steep, w);
      q  = (s * (Q_ONE - s)) >> FB;
      fm = (abs_word(pred_steep) * q) >> FB;
      pred_factor    = pred_steep[W-1] ? 32'(64'd0 - fm) : fm[W-1:0];
      pred_term_open = !last;
      r.word = s[W-1:0];
    end else if (pred_term_open) begin
      neg = w[W-1] != pred_factor[W-1];
      m   = (abs_word(w) * abs_word(pred_factor)) >> FB;
      lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
      if (m > lim) begin
        m     = lim;
        r.sat = 1'b1;
      end
      r.word = (neg && m != 0) ? 32'(64'd0 - m) : m[W-1:0];
      if (last) pred_term_open = 1'b0;
    end
    return r;
  endfunction

  // Idle length: mostly none or short, now and then long
  function automatic int pick_gap(bit quiet);
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Send one item; entered and left at a falling edge
  task automatic send_item(logic is_val, logic [W-1:0] w, logic last);
    int gap;
    gap = pick_gap(sender_quiet);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= w;
    s_axis_tuser  <= is_val;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_results.push_back(predict_dual_result(is_val, w, last));
    items_sent++;
    @(negedge clk_i);
  endtask

  // Hold off until every expected transaction has come back, then let the unit settle
  task automatic wait_drain();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (DRAIN_TAIL) @(negedge clk_i);
  endtask

  // Steepness write; only called with the unit idle
  task automatic write_steepness(logic [W-1:0] k);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= k;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    pred_steep = k;
  endtask

  function automatic logic [W-1:0] pick_argument();
    logic [W-1:0] x;
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) begin
      // mostly inside the table range for slopes near 1
      x = 32'($urandom_range(0, 32'h0800_0000)) >> $urandom_range(0, 4);
      if ($urandom_range(0, 1)) x = ~x + 32'd1;
    end else if (r < 80) begin
      x = $urandom;
    end else if (r < 90) begin
      x = 32'($urandom_range(0, 255));
      if ($urandom_range(0, 1)) x = ~x + 32'd1;
    end else begin
      case ($urandom_range(0, 4))
        0: x = 32'h7FFF_FFFF;
        1: x = 32'h8000_0000;
        2: x = 32'h0800_0000;
        3: x = 32'hF800_0000;
        default: x = '0;
      endcase
    end
    return x;
  endfunction

  function automatic logic [W-1:0] pick_gradient();
    logic [W-1:0] g;
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) begin
      g = $urandom;
    end else if (r < 90) begin
      g = 32'($urandom_range(0, 32'h0400_0000));
      if ($urandom_range(0, 1)) g = ~g + 32'd1;
    end else begin
      g = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
    end
    return g;
  endfunction

  // Reset slope: open/close rules, no-term gradients, saturation of s at both ends
  task automatic test_term_rules();
    send_item(1'b0, 32'h0100_0000, 1'b0);  // gradient before any value
    send_item(1'b1, 32'h0000_0000, 1'b0);  // s = 0.5
    send_item(1'b0, 32'h7FFF_FFFF, 1'b0);
    send_item(1'b0, 32'h8000_0000, 1'b0);
    send_item(1'b0, 32'h0000_0000, 1'b0);
    send_item(1'b0, 32'hFF00_0000, 1'b1);  // closes the term
    send_item(1'b0, 32'h0100_0000, 1'b1);  // no term open
    send_item(1'b1, 32'h0100_0000, 1'b1);  // term without gradient
    send_item(1'b0, 32'h1234_5678, 1'b0);  // still no term
    send_item(1'b1, 32'h0800_0000, 1'b0);  // |z| = 8: s = 1, factor 0
    send_item(1'b0, 32'h7FFF_FFFF, 1'b1);
    send_item(1'b1, 32'hF800_0000, 1'b0);  // s = 0
    send_item(1'b1, 32'h07FF_FFFF, 1'b0);  // just below the table end, reopens
    send_item(1'b0, 32'h8000_0000, 1'b1);
    send_item(1'b1, 32'h7FFF_FFFF, 1'b1);
    send_item(1'b1, 32'h8000_0000, 1'b0);
    send_item(1'b0, 32'h0100_0000, 1'b1);
    wait_drain();
  endtask

  // Slope extremes: large factors clip gradients in both directions; a zero slope gives factor 0
  task automatic test_steepness_extremes();
    write_steepness(32'h7FFF_FFFF);
    send_item(1'b1, 32'h0000_0000, 1'b0);
    send_item(1'b0, 32'h7FFF_FFFF, 1'b0);
    send_item(1'b0, 32'h8000_0000, 1'b1);
    send_item(1'b1, 32'h0000_0001, 1'b0);
    send_item(1'b0, 32'h0001_0000, 1'b1);
    wait_drain();
    write_steepness(32'h8000_0000);
    send_item(1'b1, 32'h0000_0000, 1'b0);
    send_item(1'b0, 32'h8000_0000, 1'b0);
    send_item(1'b0, 32'h7FFF_FFFF, 1'b1);
    wait_drain();
    write_steepness(32'h0000_0000);
    send_item(1'b1, $urandom, 1'b0);
    send_item(1'b0, $urandom, 1'b1);
    wait_drain();
  endtask

  // Random terms under several slopes; mostly well-formed, some noise
  task automatic test_random_terms();
    logic [W-1:0] k;
    int phase_start, n_grad, r;
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: k = STEEP_ONE;
        1: k = 32'($urandom_range(32'h0040_0000, 32'h0400_0000));
        2: k = $urandom;
        3: k = ~32'($urandom_range(32'h0080_0000, 32'h0200_0000)) + 32'd1;
        default: k = 32'($urandom_range(32'h0800_0000, 32'h4000_0000));
      endcase
      if (phase == 1 && $urandom_range(0, 1)) k = ~k + 32'd1;
      write_steepness(k);
      sender_quiet   = (phase == 2);
      receiver_quiet = (phase == 2);
      phase_start    = items_sent;
      while (items_sent - phase_start < 246) begin
        r = $urandom_range(0, 99);
        if ($urandom_range(0, 99) < 2) wait_drain();
        if (r < 85) begin
          n_grad = $urandom_range(1, 6);
          send_item(1'b1, pick_argument(), 1'b0);
          for (int i = 0; i < n_grad; i++) begin
            send_item(1'b0, pick_gradient(), i == n_grad - 1);
          end
        end else if (r < 90) begin
          send_item(1'b1, pick_argument(), 1'b1);
        end else if (r < 95) begin
          send_item(1'b0, pick_gradient(), 1'($urandom_range(0, 1)));
          items_sent--;
        end else begin
          // term left open, the next value replaces it
          n_grad = $urandom_range(0, 2);
          send_item(1'b1, pick_argument(), 1'b0);
          for (int i = 0; i < n_grad; i++) send_item(1'b0, pick_gradient(), 1'b0);
        end
      end
      wait_drain();
    end
    sender_quiet   = 1'b0;
    receiver_quiet = 1'b0;
  endtask

  // Output side: random back-pressure
  initial begin
    m_axis_tready = 1'b0;
    @(negedge clk_i);
    forever begin
      int stall;
      stall = pick_gap(receiver_quiet);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
  end

  // Compare each output transaction with the oldest expectation
  always @(posedge clk_i) begin : check_results
    dual_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: word %h tuser %b last %b",
               m_axis_tdata, m_axis_tuser, m_axis_tlast);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tdata !== want.word) begin
          $error("result_word: expected %h, actual %h", want.word, m_axis_tdata);
          fail_count++;
        end
        if (m_axis_tuser[0] !== want.value) begin
          $error("value_out: expected %b, actual %b", want.value, m_axis_tuser[0]);
          fail_count++;
        end
        if (m_axis_tlast !== want.last) begin
          $error("last_out: expected %b, actual %b", want.last, m_axis_tlast);
          fail_count++;
        end
        if (m_axis_tuser[1] !== want.sat) begin
          $error("saturated: expected %b, actual %b", want.sat, m_axis_tuser[1]);
          fail_count++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    rst_ni         = 1'b0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    s_axis_tuser   = 1'b0;
    s_axis_tlast   = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_wdata_i    = '0;
    fail_count     = 0;
    items_sent     = 0;
    cycle_count    = 0;
    sender_quiet   = 1'b0;
    receiver_quiet = 1'b0;
    pred_steep     = STEEP_ONE;
    pred_factor    = '0;
    pred_term_open = 1'b0;
    build_sig_points();
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_term_rules();
    test_steepness_extremes();
    test_random_terms();
    wait_drain();

    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/sdne_pkg.sv
rtl/core/sdne_useq.sv
rtl/core/sdne_dpath.sv
rtl/core/sigmoid_dual_number_eval_unit.sv
dv/tb_top.sv
